FILE: rtl/set_pkg.sv
// Shared types and codes for the stylus event tracker.
package set_pkg;

    // opcodes
    localparam logic [1:0] OP_RAW      = 2'd0;
    localparam logic [1:0] OP_RESYNCED = 2'd1;
    localparam logic [1:0] OP_DEV_LOST = 2'd2;

    // evdev event types
    localparam logic [15:0] EV_SYN = 16'h0000;
    localparam logic [15:0] EV_KEY = 16'h0001;
    localparam logic [15:0] EV_ABS = 16'h0003;

    // sync codes
    localparam logic [15:0] SYN_REPORT  = 16'h0000;
    localparam logic [15:0] SYN_DROPPED = 16'h0003;

    // axis codes
    localparam logic [15:0] ABS_X        = 16'h0000;
    localparam logic [15:0] ABS_Y        = 16'h0001;
    localparam logic [15:0] ABS_PRESSURE = 16'h0018;
    localparam logic [15:0] ABS_DISTANCE = 16'h0019;
    localparam logic [15:0] ABS_TILT_X   = 16'h001a;
    localparam logic [15:0] ABS_TILT_Y   = 16'h001b;

    // key codes
    localparam logic [15:0] BTN_TOOL_PEN    = 16'h0140;
    localparam logic [15:0] BTN_TOOL_RUBBER = 16'h0141;
    localparam logic [15:0] BTN_TOUCH       = 16'h014a;
    localparam logic [15:0] BTN_SIDE_LOWER  = 16'h014b;
    localparam logic [15:0] BTN_SIDE_UPPER  = 16'h014c;

    // key bit positions
    localparam int KB_PEN     = 0;
    localparam int KB_RUBBER  = 1;
    localparam int KB_TOUCH   = 2;
    localparam int KB_STYLUS  = 3;
    localparam int KB_STYLUS2 = 4;

    // phase kinds
    localparam logic [2:0] PH_ADD    = 3'd0;
    localparam logic [2:0] PH_DOWN   = 3'd1;
    localparam logic [2:0] PH_MOVE   = 3'd2;
    localparam logic [2:0] PH_HOVER  = 3'd3;
    localparam logic [2:0] PH_UP     = 3'd4;
    localparam logic [2:0] PH_CANCEL = 3'd5;
    localparam logic [2:0] PH_REMOVE = 3'd6;
    localparam logic [2:0] PH_SAMPLE = 3'd7;

    // tools
    localparam logic [1:0] TOOL_NONE   = 2'd0;
    localparam logic [1:0] TOOL_TIP    = 2'd1;
    localparam logic [1:0] TOOL_ERASER = 2'd2;

    // transition bits
    localparam logic [5:0] TR_ADDED    = 6'b000001;
    localparam logic [5:0] TR_DOWN     = 6'b000010;
    localparam logic [5:0] TR_UP       = 6'b000100;
    localparam logic [5:0] TR_REMOVED  = 6'b001000;
    localparam logic [5:0] TR_CANCELED = 6'b010000;
    localparam logic [5:0] TR_RESYNC   = 6'b100000;

    // status bit for a lost device
    localparam logic [4:0] ST_DEV_LOST = 5'b10000;

    localparam logic [15:0] U16_MAX = 16'hffff;

    // pointer phases queued ahead of the sample
    localparam int PTR_SLOTS = 4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        ev_type;
        logic [15:0]        ev_code;
        logic signed [31:0] ev_value;
        logic [62:0]        timestamp_us;
    } t_in_beat;

    typedef struct packed {
        logic               is_last;
        logic [62:0]        stamp_us;
        logic [2:0]         phase_kind;
        logic [1:0]         pen_tool;
        logic [4:0]         status_bits;
        logic [5:0]         transition_bits;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        pressure_level;
        logic [15:0]        hover_distance;
        logic signed [15:0] tilt_horizontal;
        logic signed [15:0] tilt_vertical;
    } t_out_beat;

endpackage

FILE: rtl/set_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface set_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/stylus_event_tracker_unit.sv
// Stylus event tracker: evdev event intake, pen state, pointer phase and sample output.
// Path: an accepted report or device-lost beat reaches its first result beat via the input
//   register, then the burst register; other beats update state from the input register.
// Throughput: one input beat per cycle unless the input register stalls; beats without results
//   keep flowing while a burst drains. A burst holds n result beats (n = 1..5), and the next
//   report or device-lost beat waits in the input register until that burst's sample is taken.
// Reset: synchronous, active low; clears axes, keys, flags, pen state and both valid bits.
module stylus_event_tracker_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    set_chan_if.sink      i_in,
    set_chan_if.source    o_out
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic              r_in_vld;
    set_pkg::t_in_beat r_in;

    // ------------------------------------------------------------------
    // Tracker state
    // ------------------------------------------------------------------
    logic [15:0] r_ax_x, r_ax_y, r_ax_p, r_ax_d, r_ax_tx, r_ax_ty;
    logic [4:0]  r_keys;
    logic        r_dirty, r_dropping, r_resync;
    logic [1:0]  r_tool;
    logic        r_in_range, r_contact;

    logic [15:0] n_ax_x, n_ax_y, n_ax_p, n_ax_d, n_ax_tx, n_ax_ty;
    logic [4:0]  n_keys;
    logic        n_dirty, n_dropping, n_resync;
    logic [1:0]  n_tool;
    logic        n_in_range, n_contact;

    // ------------------------------------------------------------------
    // Burst register: pointer phases queued in front of one sample.
    // Axes are snapshotted since later beats may change them.
    // ------------------------------------------------------------------
    logic        r_b_vld;
    logic [2:0]  r_b_cnt;
    logic [2:0]  r_b_kind [set_pkg::PTR_SLOTS];
    logic [1:0]  r_b_ptool[set_pkg::PTR_SLOTS];
    logic [62:0] r_b_stamp;
    logic [15:0] r_b_x, r_b_y, r_b_p, r_b_d, r_b_tx, r_b_ty;
    logic [1:0]  r_b_btn;       // {stylus2, stylus} for pointer beats
    logic [1:0]  r_b_s_tool;
    logic [4:0]  r_b_s_status;
    logic [5:0]  r_b_s_trans;

    // burst being built from the input register
    logic        gen;
    logic [2:0]  p_cnt;
    logic [2:0]  p_kind [set_pkg::PTR_SLOTS];
    logic [1:0]  p_tool [set_pkg::PTR_SLOTS];
    logic [1:0]  s_tool;
    logic [4:0]  s_status;
    logic [5:0]  s_trans;

    // report decode
    logic [1:0]  nt;
    logic        nc, nr;
    logic [4:0]  key_mask;

    logic        b_free, in_adv, out_take;
    set_pkg::t_out_beat out_beat;

    function automatic logic [15:0] sat_u16(input logic signed [31:0] v);
        logic [15:0] res;
        if (v < 32'sd0)          res = 16'd0;
        else if (v > 32'sd65535) res = set_pkg::U16_MAX;
        else                     res = v[15:0];
        return res;
    endfunction

    function automatic logic [15:0] sat_i16(input logic signed [31:0] v);
        logic [15:0] res;
        if (v < -32'sd32768)     res = 16'h8000;
        else if (v > 32'sd32767) res = 16'h7fff;
        else                     res = v[15:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_take   = o_out.valid && o_out.ready;
    // burst register empties this cycle or already is empty
    assign b_free     = !r_b_vld || (o_out.ready && (r_b_cnt == 3'd0));
    assign in_adv     = r_in_vld && (!gen || b_free);
    assign i_in.ready = !r_in_vld || in_adv;

    // ------------------------------------------------------------------
    // Next state and burst contents for the beat in the input register
    // ------------------------------------------------------------------
    always_comb begin
        n_ax_x     = r_ax_x;
        n_ax_y     = r_ax_y;
        n_ax_p     = r_ax_p;
        n_ax_d     = r_ax_d;
        n_ax_tx    = r_ax_tx;
        n_ax_ty    = r_ax_ty;
        n_keys     = r_keys;
        n_dirty    = r_dirty;
        n_dropping = r_dropping;
        n_resync   = r_resync;
        n_tool     = r_tool;
        n_in_range = r_in_range;
        n_contact  = r_contact;

        gen      = 1'b0;
        p_cnt    = 3'd0;
        for (int i = 0; i < set_pkg::PTR_SLOTS; i++) begin
            p_kind[i] = set_pkg::PH_ADD;
            p_tool[i] = set_pkg::TOOL_NONE;
        end
        s_tool   = set_pkg::TOOL_NONE;
        s_status = 5'd0;
        s_trans  = 6'd0;

        // tool / range / contact as a report would derive them
        nc = r_keys[set_pkg::KB_TOUCH];
        if (r_keys[set_pkg::KB_RUBBER])     nt = set_pkg::TOOL_ERASER;
        else if (r_keys[set_pkg::KB_PEN])   nt = set_pkg::TOOL_TIP;
        else if (nc)                        nt = (r_tool == set_pkg::TOOL_NONE) ?
                                                 set_pkg::TOOL_TIP : r_tool;
        else                                nt = set_pkg::TOOL_NONE;
        nr = (nt != set_pkg::TOOL_NONE) || nc;

        unique case (r_in.ev_code)
            set_pkg::BTN_TOOL_PEN:    key_mask = 5'b00001;
            set_pkg::BTN_TOOL_RUBBER: key_mask = 5'b00010;
            set_pkg::BTN_TOUCH:       key_mask = 5'b00100;
            set_pkg::BTN_SIDE_LOWER:  key_mask = 5'b01000;
            set_pkg::BTN_SIDE_UPPER:  key_mask = 5'b10000;
            default:                  key_mask = 5'b00000;
        endcase

        priority if (r_in.opcode == set_pkg::OP_RESYNCED) begin
            n_dropping = 1'b0;
            n_resync   = 1'b1;
        end else if (r_in.opcode == set_pkg::OP_DEV_LOST) begin
            gen = 1'b1;
            if (r_contact) begin
                p_kind[p_cnt[1:0]] = set_pkg::PH_CANCEL;
                p_tool[p_cnt[1:0]] = r_tool;
                p_cnt   = p_cnt + 3'd1;
                s_trans = s_trans | set_pkg::TR_CANCELED;
            end
            if (r_in_range) begin
                p_kind[p_cnt[1:0]] = set_pkg::PH_REMOVE;
                p_tool[p_cnt[1:0]] = r_tool;
                p_cnt   = p_cnt + 3'd1;
                s_trans = s_trans | set_pkg::TR_REMOVED;
            end
            s_tool     = r_tool;
            s_status   = set_pkg::ST_DEV_LOST;
            n_tool     = set_pkg::TOOL_NONE;
            n_in_range = 1'b0;
            n_contact  = 1'b0;
            n_keys     = 5'd0;
        end else if (r_in.opcode == set_pkg::OP_RAW) begin
            priority if (r_in.ev_type == set_pkg::EV_SYN &&
                         r_in.ev_code == set_pkg::SYN_DROPPED) begin
                n_dropping = 1'b1;
                n_dirty    = 1'b0;
            end else if (r_dropping) begin
                // discard until the next report, then flag resync
                if (r_in.ev_type == set_pkg::EV_SYN &&
                    r_in.ev_code == set_pkg::SYN_REPORT) begin
                    n_dropping = 1'b0;
                    n_resync   = 1'b1;
                end
            end else if (r_in.ev_type == set_pkg::EV_ABS) begin
                unique case (r_in.ev_code)
                    set_pkg::ABS_X: begin
                        n_ax_x  = sat_u16(r_in.ev_value);
                        n_dirty = 1'b1;
                    end
                    set_pkg::ABS_Y: begin
                        n_ax_y  = sat_u16(r_in.ev_value);
                        n_dirty = 1'b1;
                    end
                    set_pkg::ABS_PRESSURE: begin
                        n_ax_p  = sat_u16(r_in.ev_value);
                        n_dirty = 1'b1;
                    end
                    set_pkg::ABS_DISTANCE: begin
                        n_ax_d  = sat_u16(r_in.ev_value);
                        n_dirty = 1'b1;
                    end
                    set_pkg::ABS_TILT_X: begin
                        n_ax_tx = sat_i16(r_in.ev_value);
                        n_dirty = 1'b1;
                    end
                    set_pkg::ABS_TILT_Y: begin
                        n_ax_ty = sat_i16(r_in.ev_value);
                        n_dirty = 1'b1;
                    end
                    default: ;
                endcase
            end else if (r_in.ev_type == set_pkg::EV_KEY) begin
                if (key_mask != 5'd0) begin
                    n_keys  = (r_in.ev_value != 32'sd0) ? (r_keys | key_mask)
                                                        : (r_keys & ~key_mask);
                    n_dirty = 1'b1;
                end
            end else if (r_in.ev_type == set_pkg::EV_SYN &&
                         r_in.ev_code == set_pkg::SYN_REPORT &&
                         (r_dirty || r_resync)) begin
                gen = 1'b1;
                priority if (r_in_range && nr && (r_tool != nt)) begin
                    // tool swap while in range
                    if (r_contact) begin
                        p_kind[p_cnt[1:0]] = set_pkg::PH_CANCEL;
                        p_tool[p_cnt[1:0]] = r_tool;
                        p_cnt   = p_cnt + 3'd1;
                        s_trans = s_trans | set_pkg::TR_CANCELED;
                    end
                    p_kind[p_cnt[1:0]] = set_pkg::PH_REMOVE;
                    p_tool[p_cnt[1:0]] = r_tool;
                    p_cnt   = p_cnt + 3'd1;
                    p_kind[p_cnt[1:0]] = set_pkg::PH_ADD;
                    p_tool[p_cnt[1:0]] = nt;
                    p_cnt   = p_cnt + 3'd1;
                    s_trans = s_trans | set_pkg::TR_REMOVED | set_pkg::TR_ADDED;
                    if (nc) begin
                        p_kind[p_cnt[1:0]] = set_pkg::PH_DOWN;
                        p_tool[p_cnt[1:0]] = nt;
                        p_cnt   = p_cnt + 3'd1;
                        s_trans = s_trans | set_pkg::TR_DOWN;
                    end
                end else if (!r_in_range && nr) begin
                    p_kind[p_cnt[1:0]] = set_pkg::PH_ADD;
                    p_tool[p_cnt[1:0]] = nt;
                    p_cnt   = p_cnt + 3'd1;
                    s_trans = s_trans | set_pkg::TR_ADDED;
                    if (nc) begin
                        p_kind[p_cnt[1:0]] = set_pkg::PH_DOWN;
                        p_tool[p_cnt[1:0]] = nt;
                        p_cnt   = p_cnt + 3'd1;
                        s_trans = s_trans | set_pkg::TR_DOWN;
                    end
                end else if (r_in_range && !nr) begin
                    if (r_contact) begin
                        p_kind[p_cnt[1:0]] = set_pkg::PH_UP;
                        p_tool[p_cnt[1:0]] = r_tool;
                        p_cnt   = p_cnt + 3'd1;
                        s_trans = s_trans | set_pkg::TR_UP;
                    end
                    p_kind[p_cnt[1:0]] = set_pkg::PH_REMOVE;
                    p_tool[p_cnt[1:0]] = r_tool;
                    p_cnt   = p_cnt + 3'd1;
                    s_trans = s_trans | set_pkg::TR_REMOVED;
                end else if (r_in_range && nr) begin
                    p_tool[0] = nt;
                    p_cnt     = 3'd1;
                    priority if (!r_contact && nc) begin
                        p_kind[0] = set_pkg::PH_DOWN;
                        s_trans   = s_trans | set_pkg::TR_DOWN;
                    end else if (r_contact && !nc) begin
                        p_kind[0] = set_pkg::PH_UP;
                        s_trans   = s_trans | set_pkg::TR_UP;
                    end else if (nc) begin
                        p_kind[0] = set_pkg::PH_MOVE;
                    end else begin
                        p_kind[0] = set_pkg::PH_HOVER;
                    end
                end else begin
                    // out of range and staying out: sample only
                end
                if (r_resync) begin
                    s_trans  = s_trans | set_pkg::TR_RESYNC;
                    n_resync = 1'b0;
                end
                s_tool     = nt;
                s_status   = {1'b0, r_keys[set_pkg::KB_STYLUS2],
                              r_keys[set_pkg::KB_STYLUS], nc, nr};
                n_tool     = nt;
                n_in_range = nr;
                n_contact  = nc;
                n_dirty    = 1'b0;
            end else begin
                // unknown type or code
            end
        end else begin
            // unused opcode
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_ax_x     <= 16'd0;
            r_ax_y     <= 16'd0;
            r_ax_p     <= 16'd0;
            r_ax_d     <= 16'd0;
            r_ax_tx    <= 16'd0;
            r_ax_ty    <= 16'd0;
            r_keys     <= 5'd0;
            r_dirty    <= 1'b0;
            r_dropping <= 1'b0;
            r_resync   <= 1'b0;
            r_tool     <= set_pkg::TOOL_NONE;
            r_in_range <= 1'b0;
            r_contact  <= 1'b0;
            r_b_vld    <= 1'b0;
            r_b_cnt    <= 3'd0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (in_adv) begin
                r_ax_x     <= n_ax_x;
                r_ax_y     <= n_ax_y;
                r_ax_p     <= n_ax_p;
                r_ax_d     <= n_ax_d;
                r_ax_tx    <= n_ax_tx;
                r_ax_ty    <= n_ax_ty;
                r_keys     <= n_keys;
                r_dirty    <= n_dirty;
                r_dropping <= n_dropping;
                r_resync   <= n_resync;
                r_tool     <= n_tool;
                r_in_range <= n_in_range;
                r_contact  <= n_contact;
            end
            if (in_adv && gen) begin
                r_b_vld <= 1'b1;
                r_b_cnt <= p_cnt;
            end else if (out_take) begin
                if (r_b_cnt != 3'd0) begin
                    r_b_cnt <= r_b_cnt - 3'd1;
                end else begin
                    r_b_vld <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (in_adv && gen) begin
            r_b_stamp    <= r_in.timestamp_us;
            r_b_x        <= r_ax_x;
            r_b_y        <= r_ax_y;
            r_b_p        <= r_ax_p;
            r_b_d        <= r_ax_d;
            r_b_tx       <= r_ax_tx;
            r_b_ty       <= r_ax_ty;
            r_b_btn      <= {r_keys[set_pkg::KB_STYLUS2], r_keys[set_pkg::KB_STYLUS]};
            r_b_s_tool   <= s_tool;
            r_b_s_status <= s_status;
            r_b_s_trans  <= s_trans;
            for (int i = 0; i < set_pkg::PTR_SLOTS; i++) begin
                r_b_kind[i]  <= p_kind[i];
                r_b_ptool[i] <= p_tool[i];
            end
        end else if (out_take && (r_b_cnt != 3'd0)) begin
            // shift the pointer queue toward slot 0
            for (int i = 0; i < set_pkg::PTR_SLOTS - 1; i++) begin
                r_b_kind[i]  <= r_b_kind[i + 1];
                r_b_ptool[i] <= r_b_ptool[i + 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output beat: queued pointer phase first, sample last
    // ------------------------------------------------------------------
    always_comb begin
        out_beat.stamp_us       = r_b_stamp;
        out_beat.pos_x          = r_b_x;
        out_beat.pos_y          = r_b_y;
        out_beat.pressure_level = r_b_p;
        if (r_b_cnt != 3'd0) begin
            out_beat.is_last         = 1'b0;
            out_beat.phase_kind      = r_b_kind[0];
            out_beat.pen_tool        = r_b_ptool[0];
            out_beat.status_bits     = {1'b0, r_b_btn, 2'b00};
            out_beat.transition_bits = 6'd0;
            out_beat.hover_distance  = 16'd0;
            out_beat.tilt_horizontal = 16'sd0;
            out_beat.tilt_vertical   = 16'sd0;
        end else begin
            out_beat.is_last         = 1'b1;
            out_beat.phase_kind      = set_pkg::PH_SAMPLE;
            out_beat.pen_tool        = r_b_s_tool;
            out_beat.status_bits     = r_b_s_status;
            out_beat.transition_bits = r_b_s_trans;
            out_beat.hover_distance  = r_b_d;
            out_beat.tilt_horizontal = r_b_tx;
            out_beat.tilt_vertical   = r_b_ty;
        end
    end

    assign o_out.valid = r_b_vld;
    assign o_out.data  = out_beat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_cnt <= 3'd4)
        else $error("pointer queue count out of range");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !o_out.data.is_last) |=> o_out.valid)
        else $error("burst ended before its sample");

    a_contact_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_contact |-> r_in_range)
        else $error("contact without range");

    a_lost_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.is_last && o_out.data.status_bits[4])
            |-> (o_out.data.status_bits[3:0] == 4'd0))
        else $error("device-lost sample with live status");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !in_adv) |=> (r_in_vld && $stable(r_in)))
        else $error("input register lost a stalled beat");

endmodule

FILE: verif/tb_stylus_event_tracker_unit.sv
// Self-checking testbench for stylus_event_tracker_unit: evdev stimulus, pen state predictor.
module tb_stylus_event_tracker_unit;
    import set_pkg::*;

    // Opcode 3 has no meaning and must be swallowed without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS    = 110;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PRINT_CAP      = 100;
    localparam int PHASE_BEATS    = 32;

    logic i_clk;
    logic i_rst_n;

    set_chan_if #(.T(t_in_beat))  in_ch ();
    set_chan_if #(.T(t_out_beat)) out_ch ();

    stylus_event_tracker_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------
    // Queues and run counters
    // ------------------------------------------------------------------
    t_in_beat  evdev_backlog [$];   // beats still to be offered to the block
    t_out_beat pen_beats_due [$];   // predicted result beats, oldest first
    t_out_beat want_beat;

    int unsigned cycle_count     = 0;
    int          beats_in        = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          noise_beats     = 0;
    int          directed_beats  = 0;
    int          kind_seen [8]   = '{default: 0};

    // ------------------------------------------------------------------
    // Tracker state mirrored by the predictor (reset values)
    // ------------------------------------------------------------------
    logic [15:0] axis_x_now     = '0;
    logic [15:0] axis_y_now     = '0;
    logic [15:0] axis_press_now = '0;
    logic [15:0] axis_dist_now  = '0;
    logic [15:0] tilt_x_now     = '0;
    logic [15:0] tilt_y_now     = '0;
    logic [4:0]  key_state      = '0;
    bit          frame_dirty    = 1'b0;
    bit          drop_mode      = 1'b0;
    bit          resync_due     = 1'b0;
    logic [1:0]  pen_tool_now   = TOOL_NONE;
    bit          pen_in_range   = 1'b0;
    bit          pen_contact    = 1'b0;

    // ------------------------------------------------------------------
    // Clock and the single reset pulse
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                   results_checked, name, got, want));
    endtask

    task automatic compare_beat(input t_out_beat got, input t_out_beat want);
        check_field("is_last",         64'(got.is_last),         64'(want.is_last));
        check_field("stamp_us",        64'(got.stamp_us),        64'(want.stamp_us));
        check_field("phase_kind",      64'(got.phase_kind),      64'(want.phase_kind));
        check_field("pen_tool",        64'(got.pen_tool),        64'(want.pen_tool));
        check_field("status_bits",     64'(got.status_bits),     64'(want.status_bits));
        check_field("transition_bits", 64'(got.transition_bits), 64'(want.transition_bits));
        check_field("pos_x",           64'(got.pos_x),           64'(want.pos_x));
        check_field("pos_y",           64'(got.pos_y),           64'(want.pos_y));
        check_field("pressure_level",  64'(got.pressure_level),  64'(want.pressure_level));
        check_field("hover_distance",  64'(got.hover_distance),  64'(want.hover_distance));
        check_field("tilt_horizontal", 64'(got.tilt_horizontal), 64'(want.tilt_horizontal));
        check_field("tilt_vertical",   64'(got.tilt_vertical),   64'(want.tilt_vertical));
    endtask

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] limit_u16(input logic signed [31:0] v);
        if (v < 0)
            return 16'd0;
        if (v > 32'sd65535)
            return U16_MAX;
        return v[15:0];
    endfunction

    function automatic logic [15:0] limit_s16(input logic signed [31:0] v);
        if (v < -32'sd32768)
            return 16'h8000;
        if (v > 32'sd32767)
            return 16'h7fff;
        return v[15:0];
    endfunction

    // Side-button bits only; range/contact/lost are filled in by the caller.
    function automatic logic [4:0] button_status();
        return {1'b0, key_state[KB_STYLUS2], key_state[KB_STYLUS], 2'b00};
    endfunction

    // Pointer phase beat: no transitions, no distance, no tilt.
    task automatic emit_phase(input logic [2:0] kind, input logic [1:0] tool,
                              input logic [62:0] ts);
        t_out_beat b;
        b                = '0;
        b.stamp_us       = ts;
        b.phase_kind     = kind;
        b.pen_tool       = tool;
        b.status_bits    = button_status();
        b.pos_x          = axis_x_now;
        b.pos_y          = axis_y_now;
        b.pressure_level = axis_press_now;
        pen_beats_due.push_back(b);
    endtask

    // Sample beat closes every burst, so it carries is_last.
    task automatic emit_sample(input logic [1:0] tool, input logic [4:0] status,
                               input logic [5:0] trans, input logic [62:0] ts);
        t_out_beat b;
        b                 = '0;
        b.is_last         = 1'b1;
        b.stamp_us        = ts;
        b.phase_kind      = PH_SAMPLE;
        b.pen_tool        = tool;
        b.status_bits     = status;
        b.transition_bits = trans;
        b.pos_x           = axis_x_now;
        b.pos_y           = axis_y_now;
        b.pressure_level  = axis_press_now;
        b.hover_distance  = axis_dist_now;
        b.tilt_horizontal = tilt_x_now;
        b.tilt_vertical   = tilt_y_now;
        pen_beats_due.push_back(b);
    endtask

    // ------------------------------------------------------------------
    // Predictor: advance the mirrored tracker by one accepted input beat
    // and queue whatever result beats it produces.
    // ------------------------------------------------------------------
    task automatic track_stylus_event(input t_in_beat b);
        logic [1:0] nt;
        logic       nc;
        logic       nr;
        logic [5:0] tr;
        int         kbit;
        tr   = '0;
        kbit = -1;
        case (b.opcode)
            OP_RESYNCED: begin
                drop_mode  = 1'b0;
                resync_due = 1'b1;
            end
            OP_DEV_LOST: begin
                // Lost device: cancel a held contact, remove a pen in range,
                // then a sample flagged lost; all keys forgotten.
                if (pen_contact) begin
                    emit_phase(PH_CANCEL, pen_tool_now, b.timestamp_us);
                    tr |= TR_CANCELED;
                end
                if (pen_in_range) begin
                    emit_phase(PH_REMOVE, pen_tool_now, b.timestamp_us);
                    tr |= TR_REMOVED;
                end
                emit_sample(pen_tool_now, ST_DEV_LOST, tr, b.timestamp_us);
                pen_tool_now = TOOL_NONE;
                pen_in_range = 1'b0;
                pen_contact  = 1'b0;
                key_state    = '0;
            end
            OP_RAW: begin
                if (b.ev_type == EV_SYN && b.ev_code == SYN_DROPPED) begin
                    // Dropped sync wins even while already dropping.
                    drop_mode   = 1'b1;
                    frame_dirty = 1'b0;
                end else if (drop_mode) begin
                    // Everything is discarded until a report; that report only
                    // ends the drop and arms the resync mark.
                    if (b.ev_type == EV_SYN && b.ev_code == SYN_REPORT) begin
                        drop_mode  = 1'b0;
                        resync_due = 1'b1;
                    end
                end else if (b.ev_type == EV_ABS) begin
                    case (b.ev_code)
                        ABS_X:        axis_x_now     = limit_u16(b.ev_value);
                        ABS_Y:        axis_y_now     = limit_u16(b.ev_value);
                        ABS_PRESSURE: axis_press_now = limit_u16(b.ev_value);
                        ABS_DISTANCE: axis_dist_now  = limit_u16(b.ev_value);
                        ABS_TILT_X:   tilt_x_now     = limit_s16(b.ev_value);
                        ABS_TILT_Y:   tilt_y_now     = limit_s16(b.ev_value);
                        default: ;
                    endcase
                    if (b.ev_code inside {ABS_X, ABS_Y, ABS_PRESSURE, ABS_DISTANCE,
                                          ABS_TILT_X, ABS_TILT_Y})
                        frame_dirty = 1'b1;
                end else if (b.ev_type == EV_KEY) begin
                    case (b.ev_code)
                        BTN_TOOL_PEN:    kbit = KB_PEN;
                        BTN_TOOL_RUBBER: kbit = KB_RUBBER;
                        BTN_TOUCH:       kbit = KB_TOUCH;
                        BTN_SIDE_LOWER:  kbit = KB_STYLUS;
                        BTN_SIDE_UPPER:  kbit = KB_STYLUS2;
                        default:         kbit = -1;
                    endcase
                    if (kbit >= 0) begin
                        key_state[kbit] = (b.ev_value != 0);
                        frame_dirty     = 1'b1;
                    end
                end else if (b.ev_type == EV_SYN && b.ev_code == SYN_REPORT &&
                             (frame_dirty || resync_due)) begin
                    // Tool choice: eraser beats tip; touch alone keeps the
                    // current tool, or picks tip when none is set.
                    if (key_state[KB_RUBBER])
                        nt = TOOL_ERASER;
                    else if (key_state[KB_PEN])
                        nt = TOOL_TIP;
                    else if (key_state[KB_TOUCH])
                        nt = (pen_tool_now == TOOL_NONE) ? TOOL_TIP : pen_tool_now;
                    else
                        nt = TOOL_NONE;
                    nc = key_state[KB_TOUCH];
                    nr = (nt != TOOL_NONE) || nc;
                    if (nt == TOOL_NONE && nc)
                        nt = TOOL_TIP;

                    if (pen_in_range && nr && pen_tool_now != nt) begin
                        // Tool swap in range: tear down the old pen, bring up the new.
                        if (pen_contact) begin
                            emit_phase(PH_CANCEL, pen_tool_now, b.timestamp_us);
                            tr |= TR_CANCELED;
                        end
                        emit_phase(PH_REMOVE, pen_tool_now, b.timestamp_us);
                        tr |= TR_REMOVED;
                        emit_phase(PH_ADD, nt, b.timestamp_us);
                        tr |= TR_ADDED;
                        if (nc) begin
                            emit_phase(PH_DOWN, nt, b.timestamp_us);
                            tr |= TR_DOWN;
                        end
                    end else if (!pen_in_range && nr) begin
                        emit_phase(PH_ADD, nt, b.timestamp_us);
                        tr |= TR_ADDED;
                        if (nc) begin
                            emit_phase(PH_DOWN, nt, b.timestamp_us);
                            tr |= TR_DOWN;
                        end
                    end else if (pen_in_range && !nr) begin
                        if (pen_contact) begin
                            emit_phase(PH_UP, pen_tool_now, b.timestamp_us);
                            tr |= TR_UP;
                        end
                        emit_phase(PH_REMOVE, pen_tool_now, b.timestamp_us);
                        tr |= TR_REMOVED;
                    end else if (pen_in_range && nr) begin
                        if (!pen_contact && nc) begin
                            emit_phase(PH_DOWN, nt, b.timestamp_us);
                            tr |= TR_DOWN;
                        end else if (pen_contact && !nc) begin
                            emit_phase(PH_UP, nt, b.timestamp_us);
                            tr |= TR_UP;
                        end else if (nc) begin
                            emit_phase(PH_MOVE, nt, b.timestamp_us);
                        end else begin
                            emit_phase(PH_HOVER, nt, b.timestamp_us);
                        end
                    end
                    if (resync_due) begin
                        tr |= TR_RESYNC;
                        resync_due = 1'b0;
                    end
                    emit_sample(nt, button_status() | {3'b000, nc, nr}, tr, b.timestamp_us);
                    pen_tool_now = nt;
                    pen_in_range = nr;
                    pen_contact  = nc;
                    frame_dirty  = 1'b0;
                end
            end
            default: ;   // unused opcode: nothing happens
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_event(input logic [1:0] op, input logic [15:0] ev_type,
                               input logic [15:0] ev_code, input logic signed [31:0] ev_value);
        t_in_beat   b;
        logic [63:0] ts;
        ts             = {$urandom, $urandom};
        b.opcode       = op;
        b.ev_type      = ev_type;
        b.ev_code      = ev_code;
        b.ev_value     = ev_value;
        b.timestamp_us = ts[62:0];
        evdev_backlog.push_back(b);
    endtask

    // One axis or key update with random content; keys lean toward the
    // tool and touch keys so that tool swaps and contact changes are common.
    task automatic queue_field_event();
        logic [15:0]        code;
        logic signed [31:0] v;
        if ($urandom_range(1) == 1) begin
            case ($urandom_range(5))
                0: code = ABS_X;
                1: code = ABS_Y;
                2: code = ABS_PRESSURE;
                3: code = ABS_DISTANCE;
                4: code = ABS_TILT_X;
                default: code = ABS_TILT_Y;
            endcase
            case ($urandom_range(4))
                0: v = $urandom;
                1: v = $urandom_range(65535);
                2: v = 32'sd65534 + $urandom_range(2);          // around the unsigned ceiling
                3: v = int'($urandom_range(80000)) - 40000;     // both tilt rails
                default: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            endcase
            queue_event(OP_RAW, EV_ABS, code, v);
        end else begin
            case ($urandom_range(9))
                0, 1, 2: code = BTN_TOOL_PEN;
                3, 4:    code = BTN_TOOL_RUBBER;
                5, 6, 7: code = BTN_TOUCH;
                8:       code = BTN_SIDE_LOWER;
                default: code = BTN_SIDE_UPPER;
            endcase
            if ($urandom_range(9) < 5)
                v = 0;
            else if ($urandom_range(9) < 8)
                v = 1;
            else
                v = $urandom;
            queue_event(OP_RAW, EV_KEY, code, v);
        end
    endtask

    // Pacing phases, stepped by accepted beats: none, sender idle,
    // receiver stall, both lightly.
    function automatic int idle_share(input bit for_sender);
        case ((beats_in / PHASE_BEATS) % 4)
            0:       return 0;
            1:       return for_sender ? 54 : 0;
            2:       return for_sender ? 0 : 54;
            default: return 10;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: holds a beat until ready, predicts it on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                track_stylus_event(in_ch.data);
                beats_in++;
            end
            if (evdev_backlog.size() != 0 && $urandom_range(99) >= idle_share(1'b1)) begin
                in_ch.data  <= evdev_backlog.pop_front();
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, field-by-field check of each result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_share(1'b0));
            if (out_ch.valid && out_ch.ready) begin
                if (pen_beats_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected result beat, phase kind %0d",
                                           out_ch.data.phase_kind));
                end else begin
                    want_beat = pen_beats_due.pop_front();
                    compare_beat(out_ch.data, want_beat);
                    kind_seen[want_beat.phase_kind]++;
                    results_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles: %0d beats unsent, %0d results outstanding",
                     cycle_count, evdev_backlog.size(), pen_beats_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build and end of run
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        // Directed: report with nothing pending, axis saturation on every
        // axis, pen arrival, touch, tool swap under contact (longest burst),
        // lift, dropped sync and its resync, no-op opcodes, device loss.
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);
        queue_event(OP_RAW, EV_ABS, ABS_X, -5);
        queue_event(OP_RAW, EV_ABS, ABS_Y, 70000);
        queue_event(OP_RAW, EV_ABS, ABS_PRESSURE, 32'sh7fffffff);
        queue_event(OP_RAW, EV_ABS, ABS_DISTANCE, 32'sh80000000);
        queue_event(OP_RAW, EV_ABS, ABS_TILT_X, -100000);
        queue_event(OP_RAW, EV_ABS, ABS_TILT_Y, 40000);
        queue_event(OP_RAW, EV_KEY, BTN_TOOL_PEN, 1);
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);        // add
        queue_event(OP_RAW, EV_KEY, BTN_TOUCH, 1);
        queue_event(OP_RAW, EV_KEY, BTN_SIDE_LOWER, 1);
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);        // down
        queue_event(OP_RAW, EV_KEY, BTN_TOOL_RUBBER, 1);
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);        // cancel, remove, add, down
        queue_event(OP_RAW, EV_KEY, BTN_TOUCH, 0);
        queue_event(OP_RAW, EV_KEY, BTN_SIDE_UPPER, -1);
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);        // up
        queue_event(OP_RAW, EV_SYN, SYN_DROPPED, 0);
        queue_event(OP_RAW, EV_ABS, ABS_Y, 77);            // discarded
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);        // ends the drop only
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);        // hover with resync
        queue_event(OP_UNUSED, 16'($urandom), 16'($urandom), $urandom);
        queue_event(OP_RESYNCED, EV_SYN, SYN_REPORT, 0);
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);        // hover with resync
        queue_event(OP_RAW, EV_KEY, BTN_TOUCH, 1);
        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);        // down
        queue_event(OP_DEV_LOST, EV_SYN, SYN_REPORT, 0);   // cancel, remove, lost sample
        directed_beats = evdev_backlog.size();

        // Random: mostly well-formed frames closed by a report; the rest is
        // drops, resync marks, device loss, lone reports and ignored noise.
        while (evdev_backlog.size() < TOTAL_ITEMS) begin
            case ($urandom_range(99)) inside
                [0:69]: begin
                    repeat ($urandom_range(1, 4)) queue_field_event();
                    queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);
                end
                [70:75]: begin
                    queue_event(OP_RAW, EV_SYN, SYN_DROPPED, $urandom);
                    repeat ($urandom_range(2)) queue_field_event();
                    if ($urandom_range(1) == 1)
                        queue_event(OP_RESYNCED, 16'($urandom), 16'($urandom), $urandom);
                    else
                        queue_event(OP_RAW, EV_SYN, SYN_REPORT, 0);
                end
                [76:81]: queue_event(OP_DEV_LOST, 16'($urandom), 16'($urandom), $urandom);
                [82:85]: queue_event(OP_RESYNCED, 16'($urandom), 16'($urandom), $urandom);
                [86:91]: queue_event(OP_RAW, EV_SYN, SYN_REPORT, $urandom);
                default: begin
                    noise_beats++;
                    case ($urandom_range(3))
                        0: queue_event(OP_UNUSED, 16'($urandom), 16'($urandom), $urandom);
                        1: queue_event(OP_RAW, EV_ABS, 16'(16'h0002 + $urandom_range(16'h15)),
                                       $urandom);
                        2: queue_event(OP_RAW, EV_KEY, 16'(16'h0150 + $urandom_range(16'hfe00)),
                                       $urandom);
                        default: queue_event(OP_RAW, 16'(16'h0004 + $urandom_range(16'hfff0)),
                                             16'($urandom), $urandom);
                    endcase
                end
            endcase
        end

        // Everything sent, every prediction drained, then a short quiet
        // window so that stray extra beats still get caught.
        @(posedge i_rst_n);
        while (evdev_backlog.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (pen_beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input beats (%0d directed, %0d ignored noise), %0d results",
                 beats_in, directed_beats, noise_beats, results_checked);
        $display("Result mix: add %0d down %0d move %0d hover %0d up %0d cancel %0d %s %0d %s %0d",
                 kind_seen[PH_ADD], kind_seen[PH_DOWN], kind_seen[PH_MOVE],
                 kind_seen[PH_HOVER], kind_seen[PH_UP], kind_seen[PH_CANCEL],
                 "remove", kind_seen[PH_REMOVE], "sample", kind_seen[PH_SAMPLE]);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
